// ===== rtl/core/assembler_source_tokenizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the assembler source tokenizer
// Concurrent assertions clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLER_SOURCE_TOKENIZER_UNIT_MACROS_SVH
`define ASSEMBLER_SOURCE_TOKENIZER_UNIT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define AST_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tokenizer check failed");

// A stalled item keeps its payload.
`define AST_ASSERT_HOLD(label, vld, rdy, sig) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
    else $error("tokenizer stalled item changed");

`endif

// ===== rtl/core/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// Tokenizer package
// Types, character codes and helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int unsigned ValueW    = 16;
  localparam int unsigned LineW     = 16;
  localparam int unsigned SymCntW   = 5;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [SymCntW-1:0] MaxSymbol = SymCntW'(23);

  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharSp    = 8'h20;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharLowH  = 8'h68;
  localparam logic [7:0] CharUpH   = 8'h48;
  localparam logic [7:0] HexAdjust = 8'h09;

  typedef enum logic [2:0] {
    TkEol    = 3'd0,
    TkBlank  = 3'd1,
    TkSymCh  = 3'd2,
    TkSymEnd = 3'd3,
    TkConst  = 3'd4,
    TkEoi    = 3'd5
  } token_kind_e;

  typedef enum logic [2:0] {
    ModeStart   = 3'd0,
    ModeBlank   = 3'd1,
    ModeComment = 3'd2,
    ModeNumber  = 3'd3,
    ModeSymbol  = 3'd4
  } lexer_mode_e;

  typedef struct packed {
    token_kind_e        token_kind;
    logic [ValueW-1:0]  constant_value;
    logic [7:0]         symbol_byte;
    logic [SymCntW-1:0] symbol_length;
    logic               symbol_too_long;
    logic [LineW-1:0]   line_number;
    logic               last_of_run;
  } token_t;

  typedef struct packed {
    logic       step;
    logic [7:0] char_code;
    logic       end_of_input;
  } lex_req_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } tok_pair_t;

  function automatic token_t make_token(token_kind_e kind, logic [ValueW-1:0] cval,
                                        logic [7:0] sbyte, logic [SymCntW-1:0] slen,
                                        logic sover, logic [LineW-1:0] line);
    token_t t;
    t.token_kind      = kind;
    t.constant_value  = cval;
    t.symbol_byte     = sbyte;
    t.symbol_length   = slen;
    t.symbol_too_long = sover;
    t.line_number     = line;
    t.last_of_run     = 1'b0;
    return t;
  endfunction

endpackage

// ===== rtl/core/ast_in_if.sv =====
// ----------------------------------------------------------------------------
// Tokenizer input channel
// Valid/ready channel carrying one character or an end-of-input mark.
// ----------------------------------------------------------------------------
interface ast_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

// ===== rtl/core/ast_out_if.sv =====
// ----------------------------------------------------------------------------
// Tokenizer output channel
// Valid/ready channel carrying one token.
// ----------------------------------------------------------------------------
interface ast_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] constant_value;
  logic [7:0]  symbol_byte;
  logic [4:0]  symbol_length;
  logic        symbol_too_long;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (output valid, output token_kind, output constant_value,
                  output symbol_byte, output symbol_length, output symbol_too_long,
                  output line_number, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input constant_value,
                  input symbol_byte, input symbol_length, input symbol_too_long,
                  input line_number, input last_of_run, output ready);
endinterface

// ===== rtl/core/ast_lexer.sv =====
// ----------------------------------------------------------------------------
// Tokenizer lexer core
// Mode, accumulators and counters; turns one item into up to two tokens.
// ----------------------------------------------------------------------------
module ast_lexer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ast_pkg::lex_req_t   req_i,
  output ast_pkg::tok_pair_t  tok_o
);

  ast_pkg::lexer_mode_e                mode_q, mode_d;
  logic [ast_pkg::ValueW-1:0]          hex_q, hex_d;
  logic [ast_pkg::ValueW-1:0]          dec_q, dec_d;
  logic [ast_pkg::LineW-1:0]           line_q, line_d;
  logic [ast_pkg::SymCntW-1:0]         cnt_q, cnt_d;
  logic                                ovf_q, ovf_d;

  logic [7:0] c;
  logic       is_blank, is_dec, is_hexl, is_semi, is_nl, is_hsuf;
  logic [3:0] digit;

  // start-of-token handling
  logic                        s_emit;
  ast_pkg::token_t             s_tok;
  ast_pkg::lexer_mode_e        s_mode;
  logic                        s_num, s_sym, s_eol;

  ast_pkg::tok_pair_t          tok;

  assign c        = req_i.char_code;
  assign is_blank = (c == ast_pkg::CharSp) || (c == ast_pkg::CharTab);
  assign is_dec   = (c >= ast_pkg::CharZero) && (c <= ast_pkg::CharNine);
  assign is_hexl  = ((c >= ast_pkg::CharLowA) && (c <= ast_pkg::CharLowF)) ||
                    ((c >= ast_pkg::CharUpA) && (c <= ast_pkg::CharUpF));
  assign is_semi  = (c == ast_pkg::CharSemi);
  assign is_nl    = (c == ast_pkg::CharNl);
  assign is_hsuf  = (c == ast_pkg::CharLowH) || (c == ast_pkg::CharUpH);
  assign digit    = is_dec ? 4'(c - ast_pkg::CharZero) : 4'(c + ast_pkg::HexAdjust);

  always_comb begin
    s_emit = 1'b0;
    s_num  = 1'b0;
    s_sym  = 1'b0;
    s_eol  = 1'b0;
    s_tok  = ast_pkg::make_token(ast_pkg::TkEol, '0, '0, '0, 1'b0, line_q);
    if (is_semi) begin
      s_mode = ast_pkg::ModeComment;
    end else if (is_nl) begin
      s_mode = ast_pkg::ModeStart;
      s_emit = 1'b1;
      s_eol  = 1'b1;
    end else if (is_blank) begin
      s_mode = ast_pkg::ModeBlank;
    end else if (is_dec) begin
      s_mode = ast_pkg::ModeNumber;
      s_num  = 1'b1;
    end else begin
      s_mode = ast_pkg::ModeSymbol;
      s_emit = 1'b1;
      s_sym  = 1'b1;
      s_tok  = ast_pkg::make_token(ast_pkg::TkSymCh, '0, c, '0, 1'b0, line_q);
    end
  end

  always_comb begin
    logic start;
    start  = 1'b0;
    mode_d = mode_q;
    hex_d  = hex_q;
    dec_d  = dec_q;
    line_d = line_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    tok.v0 = 1'b0;
    tok.v1 = 1'b0;
    tok.t0 = ast_pkg::make_token(ast_pkg::TkEoi, '0, '0, '0, 1'b0, line_q);
    tok.t1 = tok.t0;

    if (req_i.end_of_input) begin
      if (mode_q == ast_pkg::ModeNumber) begin
        tok.v0 = 1'b1;
        tok.v1 = 1'b1;
        tok.t0 = ast_pkg::make_token(ast_pkg::TkConst, dec_q, '0, '0, 1'b0, line_q);
      end else if (mode_q == ast_pkg::ModeSymbol) begin
        tok.v0 = 1'b1;
        tok.v1 = 1'b1;
        tok.t0 = ast_pkg::make_token(ast_pkg::TkSymEnd, '0, '0, cnt_q, ovf_q, line_q);
      end else begin
        tok.v0 = 1'b1;
      end
      mode_d = ast_pkg::ModeStart;
      hex_d  = '0;
      dec_d  = '0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end else begin
      case (mode_q)
        ast_pkg::ModeBlank: begin
          if (is_blank) begin
            mode_d = ast_pkg::ModeBlank;
          end else if (is_semi || is_nl) begin
            start = 1'b1;
          end else begin
            tok.v0 = 1'b1;
            tok.t0 = ast_pkg::make_token(ast_pkg::TkBlank, '0, '0, '0, 1'b0, line_q);
            start  = 1'b1;
          end
        end
        ast_pkg::ModeComment: begin
          if (is_nl) begin
            start = 1'b1;
          end
        end
        ast_pkg::ModeNumber: begin
          if (is_dec || is_hexl) begin
            hex_d = (hex_q << 4) | ast_pkg::ValueW'(digit);
            dec_d = (dec_q << 3) + (dec_q << 1) + ast_pkg::ValueW'(digit);
          end else if (is_hsuf) begin
            tok.v0 = 1'b1;
            tok.t0 = ast_pkg::make_token(ast_pkg::TkConst, hex_q, '0, '0, 1'b0, line_q);
            mode_d = ast_pkg::ModeStart;
          end else begin
            tok.v0 = 1'b1;
            tok.t0 = ast_pkg::make_token(ast_pkg::TkConst, dec_q, '0, '0, 1'b0, line_q);
            start  = 1'b1;
          end
        end
        ast_pkg::ModeSymbol: begin
          if (is_blank || is_semi || is_nl) begin
            tok.v0 = 1'b1;
            tok.t0 = ast_pkg::make_token(ast_pkg::TkSymEnd, '0, '0, cnt_q, ovf_q, line_q);
            cnt_d  = '0;
            ovf_d  = 1'b0;
            start  = 1'b1;
          end else begin
            tok.v0 = 1'b1;
            tok.t0 = ast_pkg::make_token(ast_pkg::TkSymCh, '0, c, '0, 1'b0, line_q);
            if (cnt_q < ast_pkg::MaxSymbol) begin
              cnt_d = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        default: begin
          start = 1'b1;
        end
      endcase

      if (start) begin
        mode_d = s_mode;
        if (s_num) begin
          hex_d = ast_pkg::ValueW'(digit);
          dec_d = ast_pkg::ValueW'(digit);
        end
        if (s_sym) begin
          cnt_d = ast_pkg::SymCntW'(1);
          ovf_d = 1'b0;
        end
        if (s_eol) begin
          line_d = line_q + 1'b1;
        end
        if (s_emit) begin
          if (tok.v0) begin
            tok.v1 = 1'b1;
            tok.t1 = s_tok;
          end else begin
            tok.v0 = 1'b1;
            tok.t0 = s_tok;
          end
        end
      end
    end

    if (tok.v1) begin
      tok.t1.last_of_run = 1'b1;
    end else begin
      tok.t0.last_of_run = 1'b1;
    end
  end

  assign tok_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ast_pkg::ModeStart;
      hex_q  <= '0;
      dec_q  <= '0;
      line_q <= ast_pkg::LineW'(1);
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (req_i.step) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      dec_q  <= dec_d;
      line_q <= line_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ===== rtl/core/ast_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Four-entry token queue; takes up to two tokens and gives one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module ast_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ast_pkg::tok_pair_t  tok_i,
  output logic                space2_o,
  output logic                valid_o,
  input  logic                ready_i,
  output ast_pkg::token_t     data_o
);

  ast_pkg::token_t                mem_q [ast_pkg::FifoDepth];
  logic [ast_pkg::FifoPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [ast_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic                           wr0, wr1, pop;
  logic [ast_pkg::FifoPtrW-1:0]   wr_nxt;

  assign wr0      = push_i && tok_i.v0;
  assign wr1      = push_i && tok_i.v1;
  assign pop      = valid_o && ready_i;
  assign wr_nxt   = wr_q + 1'b1;
  assign space2_o = (cnt_q <= ast_pkg::FifoCntW'(ast_pkg::FifoDepth - 2));
  assign valid_o  = (cnt_q != '0);
  assign data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + ast_pkg::FifoPtrW'(wr0) + ast_pkg::FifoPtrW'(wr1);
    rd_d  = rd_q + ast_pkg::FifoPtrW'(pop);
    cnt_d = cnt_q + ast_pkg::FifoCntW'(wr0) + ast_pkg::FifoCntW'(wr1)
            - ast_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr0) begin
      mem_q[wr_q] <= tok_i.t0;
    end
    if (wr1) begin
      mem_q[wr_nxt] <= tok_i.t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/assembler_source_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// Assembler source tokenizer
// Streams characters in and tokens out over valid/ready channels.
// ----------------------------------------------------------------------------
// in_i carries one character, or an end-of-input mark, per item. out_o carries
// tokens: end of line, blank run, symbol character, symbol end, constant and
// end of input; last_of_run marks the final token of one input item.
// An accepted item is held in the input register, then the lexer turns it
// into zero, one or two tokens that enter a four-entry result queue. A token
// passes the input register and a queue write before out_o shows it. The
// unit takes one item per cycle while the queue has room for two; out_o
// gives one token per cycle while ready, so items that make two tokens back
// up the queue and drop in_i.ready until it drains. The lexer steps only when
// the queue has room for two. When out_o stalls, the queue holds its tokens
// and in_i takes items until the input register fills and the lexer stalls.
// Reset returns the lexer to line start with line count one and empties the
// input register and the queue.
// ----------------------------------------------------------------------------
module assembler_source_tokenizer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  ast_in_if.sink    in_i,
  ast_out_if.source out_o
);

  logic                 in_valid_q;
  logic [7:0]           in_char_q;
  logic                 in_eoi_q;
  logic                 space2;
  logic                 advance;
  ast_pkg::lex_req_t    req;
  ast_pkg::tok_pair_t   tok;
  ast_pkg::token_t      head;

  assign advance    = in_valid_q && space2;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.char_code;
      in_eoi_q  <= in_i.end_of_input;
    end
  end

  assign req.step         = advance;
  assign req.char_code    = in_char_q;
  assign req.end_of_input = in_eoi_q;

  ast_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .tok_o  (tok)
  );

  ast_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (advance),
    .tok_i    (tok),
    .space2_o (space2),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .data_o   (head)
  );

  assign out_o.token_kind      = head.token_kind;
  assign out_o.constant_value  = head.constant_value;
  assign out_o.symbol_byte     = head.symbol_byte;
  assign out_o.symbol_length   = head.symbol_length;
  assign out_o.symbol_too_long = head.symbol_too_long;
  assign out_o.line_number     = head.line_number;
  assign out_o.last_of_run     = head.last_of_run;

endmodule

// ===== rtl/core/ast_checker.sv =====
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Checks token field consistency and output hold on the top-level ports.
// ----------------------------------------------------------------------------
`include "assembler_source_tokenizer_unit_macros.svh"

module ast_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  token_kind_i,
  input logic [15:0] constant_value_i,
  input logic [7:0]  symbol_byte_i,
  input logic [4:0]  symbol_length_i,
  input logic        symbol_too_long_i
);

  logic is_symend, is_const, is_symch;

  assign is_symend = (token_kind_i == ast_pkg::TkSymEnd);
  assign is_const  = (token_kind_i == ast_pkg::TkConst);
  assign is_symch  = (token_kind_i == ast_pkg::TkSymCh);

  `AST_ASSERT(a_len_bound, out_valid_i |-> (symbol_length_i <= ast_pkg::MaxSymbol))
  `AST_ASSERT(a_sym_fields, (out_valid_i && !is_symend) |-> (symbol_length_i == '0 && !symbol_too_long_i))
  `AST_ASSERT(a_other_zero, out_valid_i |-> ((is_const || constant_value_i == '0) && (is_symch || symbol_byte_i == '0)))
  `AST_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, token_kind_i)

endmodule

bind assembler_source_tokenizer_unit ast_checker u_ast_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .token_kind_i      (out_o.token_kind),
  .constant_value_i  (out_o.constant_value),
  .symbol_byte_i     (out_o.symbol_byte),
  .symbol_length_i   (out_o.symbol_length),
  .symbol_too_long_i (out_o.symbol_too_long)
);
